@@ sv/joystick_deadzone_radial_clamp_unit_assert.svh @@
// Assertion macros shared by the stick conditioning checker.
`ifndef JOYSTICK_DEADZONE_RADIAL_CLAMP_UNIT_ASSERT_SVH
`define JOYSTICK_DEADZONE_RADIAL_CLAMP_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define JDRC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define JDRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jdrc_pkg.sv @@
// Shared types, constants and the microcode program of the stick conditioning unit.
package jdrc_pkg;

    // Port and field widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int AXIS_W      = 8;
    localparam int BTN_W       = 16;
    localparam int STICK_W     = 16;
    localparam int MAG_W       = 15;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_OFFSET    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_MAGNITUDE  = 2'd2;
    localparam logic [CFG_DATA_W-1:0] RST_DEAD_THRESHOLD = 7'd8;
    localparam logic [CFG_DATA_W-1:0] RST_DEAD_OFFSET    = 7'd6;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_MAGNITUDE  = 7'd64;

    // Sequencer widths and loop counts.
    localparam int STEP_W = 5;
    localparam int CNT_W  = 5;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    localparam cnt_t DIV_ITERS  = 5'd30;
    localparam cnt_t SQRT_ITERS = 5'd16;
    localparam cnt_t CNT_LAST   = 5'd1;
    localparam cnt_t CNT_NONE   = 5'd0;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SQ,
        OP_SQ_ADD,
        OP_LIM_SQ,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_QUO,
        OP_SQRT_SUM,
        OP_SQRT_STEP,
        OP_STORE_AXIS,
        OP_STORE_RAW,
        OP_MAG_LIM,
        OP_MAG_ROOT,
        OP_OUT_WRITE
    } op_t;

    // Jump conditions: when true the step goes to the target, else to the next step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_NOT_ABOVE,
        C_CNT_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic {
        AXIS_X,
        AXIS_Y
    } axis_t;

    typedef struct packed {
        op_t   op;
        axis_t axis;
        cond_t cond;
        step_t target;
        logic  cnt_load;
        cnt_t  count;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic above;
        logic out_busy;
    } status_t;

    // Program addresses that are jump targets.
    localparam step_t ADDR_IDLE    = 5'd0;
    localparam step_t ADDR_DIV_X   = 5'd6;
    localparam step_t ADDR_SQRT_X  = 5'd8;
    localparam step_t ADDR_DIV_Y   = 5'd12;
    localparam step_t ADDR_SQRT_Y  = 5'd14;
    localparam step_t ADDR_RAW     = 5'd17;
    localparam step_t ADDR_SQRT_M  = 5'd19;
    localparam step_t ADDR_DONE    = 5'd21;

    function automatic ctrl_t uword(op_t op, axis_t ax, cond_t c, step_t tgt,
                                    logic ld, cnt_t n);
        ctrl_t w;
        w.op       = op;
        w.axis     = ax;
        w.cond     = c;
        w.target   = tgt;
        w.cnt_load = ld;
        w.count    = n;
        return w;
    endfunction

    // The microcode program, one control word per step.
    function automatic ctrl_t ucode_rom(step_t addr);
        ctrl_t w;
        unique case (addr)
            5'd0:  w = uword(OP_NOP,        AXIS_X, C_NO_START,  ADDR_IDLE,   1'b0, CNT_NONE);
            5'd1:  w = uword(OP_SQ,         AXIS_X, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            5'd2:  w = uword(OP_SQ_ADD,     AXIS_Y, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            5'd3:  w = uword(OP_LIM_SQ,     AXIS_X, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            5'd4:  w = uword(OP_NOP,        AXIS_X, C_NOT_ABOVE, ADDR_RAW,    1'b0, CNT_NONE);
            // Clamped path, horizontal axis (the square of X is still in place).
            5'd5:  w = uword(OP_DIV_INIT,   AXIS_X, C_NEXT,      ADDR_IDLE,   1'b1, DIV_ITERS);
            5'd6:  w = uword(OP_DIV_STEP,   AXIS_X, C_CNT_MORE,  ADDR_DIV_X,  1'b0, CNT_NONE);
            5'd7:  w = uword(OP_SQRT_QUO,   AXIS_X, C_NEXT,      ADDR_IDLE,   1'b1, SQRT_ITERS);
            5'd8:  w = uword(OP_SQRT_STEP,  AXIS_X, C_CNT_MORE,  ADDR_SQRT_X, 1'b0, CNT_NONE);
            5'd9:  w = uword(OP_STORE_AXIS, AXIS_X, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            // Clamped path, vertical axis.
            5'd10: w = uword(OP_SQ,         AXIS_Y, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            5'd11: w = uword(OP_DIV_INIT,   AXIS_Y, C_NEXT,      ADDR_IDLE,   1'b1, DIV_ITERS);
            5'd12: w = uword(OP_DIV_STEP,   AXIS_Y, C_CNT_MORE,  ADDR_DIV_Y,  1'b0, CNT_NONE);
            5'd13: w = uword(OP_SQRT_QUO,   AXIS_Y, C_NEXT,      ADDR_IDLE,   1'b1, SQRT_ITERS);
            5'd14: w = uword(OP_SQRT_STEP,  AXIS_Y, C_CNT_MORE,  ADDR_SQRT_Y, 1'b0, CNT_NONE);
            5'd15: w = uword(OP_STORE_AXIS, AXIS_Y, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            5'd16: w = uword(OP_MAG_LIM,    AXIS_X, C_ALWAYS,    ADDR_DONE,   1'b0, CNT_NONE);
            // Unclamped path.
            5'd17: w = uword(OP_STORE_RAW,  AXIS_X, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            5'd18: w = uword(OP_SQRT_SUM,   AXIS_X, C_NEXT,      ADDR_IDLE,   1'b1, SQRT_ITERS);
            5'd19: w = uword(OP_SQRT_STEP,  AXIS_X, C_CNT_MORE,  ADDR_SQRT_M, 1'b0, CNT_NONE);
            5'd20: w = uword(OP_MAG_ROOT,   AXIS_X, C_NEXT,      ADDR_IDLE,   1'b0, CNT_NONE);
            // Wait for the output register, then hand the result over.
            5'd21: w = uword(OP_NOP,        AXIS_X, C_OUT_BUSY,  ADDR_DONE,   1'b0, CNT_NONE);
            5'd22: w = uword(OP_OUT_WRITE,  AXIS_X, C_ALWAYS,    ADDR_IDLE,   1'b0, CNT_NONE);
            default: w = uword(OP_NOP,      AXIS_X, C_ALWAYS,    ADDR_IDLE,   1'b0, CNT_NONE);
        endcase
        return w;
    endfunction

endpackage

@@ sv/jdrc_seq.sv @@
// Microcode sequencer: step counter, loop counter and conditional jumps.
module jdrc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  jdrc_pkg::status_t stat,
    output jdrc_pkg::ctrl_t   ctrl,
    output logic              idle
);

    jdrc_pkg::step_t step_reg, step_next;
    jdrc_pkg::cnt_t  cnt_reg, cnt_next;
    logic            take;

    // Fetch the control word of the current step.
    always_comb begin
        ctrl = jdrc_pkg::ucode_rom(step_reg);
        idle = (step_reg == jdrc_pkg::ADDR_IDLE);
    end

    // Evaluate the jump condition and pick the next step.
    always_comb begin
        unique case (ctrl.cond)
            jdrc_pkg::C_NEXT:      take = 1'b0;
            jdrc_pkg::C_ALWAYS:    take = 1'b1;
            jdrc_pkg::C_NO_START:  take = !stat.start;
            jdrc_pkg::C_NOT_ABOVE: take = !stat.above;
            jdrc_pkg::C_CNT_MORE:  take = (cnt_reg != jdrc_pkg::CNT_LAST);
            jdrc_pkg::C_OUT_BUSY:  take = stat.out_busy;
            default:               take = 1'b0;
        endcase
        step_next = take ? ctrl.target : step_reg + jdrc_pkg::step_t'(1);
    end

    // The loop counter is loaded by an init step and counts down in a loop step.
    always_comb begin
        priority if (ctrl.cnt_load) begin
            cnt_next = ctrl.count;
        end else if (ctrl.cond == jdrc_pkg::C_CNT_MORE) begin
            cnt_next = cnt_reg - jdrc_pkg::CNT_LAST;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= jdrc_pkg::ADDR_IDLE;
            cnt_reg  <= jdrc_pkg::CNT_NONE;
        end else begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ sv/jdrc_datapath.sv @@
// Datapath: dead zone, squares, shared restoring divide and square root steps.
module jdrc_datapath (
    input  logic                                   aclk,
    input  jdrc_pkg::ctrl_t                        ctrl,
    input  logic                                   start,
    input  logic signed [jdrc_pkg::AXIS_W-1:0]     raw_x,
    input  logic signed [jdrc_pkg::AXIS_W-1:0]     raw_y,
    input  logic        [jdrc_pkg::CFG_DATA_W-1:0] dead_threshold,
    input  logic        [jdrc_pkg::CFG_DATA_W-1:0] dead_offset,
    input  logic        [jdrc_pkg::CFG_DATA_W-1:0] max_magnitude,
    output logic                                   above,
    output logic signed [jdrc_pkg::STICK_W-1:0]    stick_x,
    output logic signed [jdrc_pkg::STICK_W-1:0]    stick_y,
    output logic        [jdrc_pkg::MAG_W-1:0]      stick_magnitude
);

    // Dead zone on one axis; the result always fits in eight signed bits.
    function automatic logic signed [7:0] cond_axis(logic signed [7:0] r,
                                                    logic [6:0] t, logic [6:0] o);
        logic signed [8:0] rw, tw, ow, v;
        rw = {r[7], r};
        tw = {2'b00, t};
        ow = {2'b00, o};
        v  = '0;
        if (rw <= -tw) v = rw + ow;
        if (rw >= tw)  v = rw - ow;
        return v[7:0];
    endfunction

    logic signed [7:0]  vx_reg, vy_reg;
    logic        [14:0] t_reg;      // square of one axis
    logic        [15:0] s_reg;      // sum of squares
    logic        [13:0] l2_reg;     // limit squared
    logic        [31:0] wk_reg;     // dividend / quotient, then radicand
    logic        [18:0] rem_reg;    // partial remainder
    logic        [15:0] root_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic        [14:0] mag_reg;

    logic signed [7:0]  v_sel;
    logic        [8:0]  v_neg;
    logic        [7:0]  abs_v;
    logic        [15:0] sq_full;
    logic        [13:0] l2_full;
    logic        [28:0] num_full;
    logic        [16:0] d_trial, d_diff;
    logic               d_ge;
    logic        [18:0] r_trial, r_sub, r_diff;
    logic               r_ge;
    logic signed [15:0] axis_out;

    // Axis operand and its square, limit squared, dividend product and the above-limit compare.
    always_comb begin
        v_sel    = (ctrl.axis == jdrc_pkg::AXIS_Y) ? vy_reg : vx_reg;
        v_neg    = -{v_sel[7], v_sel};
        abs_v    = v_sel[7] ? v_neg[7:0] : v_sel[7:0];
        sq_full  = 16'(abs_v) * 16'(abs_v);
        l2_full  = 14'(max_magnitude) * 14'(max_magnitude);
        num_full = 29'(t_reg) * 29'(l2_reg);
        above    = (s_reg > {2'b00, l2_reg});
    end

    // One restoring divide step: bring down a bit, subtract the sum of squares if it fits.
    always_comb begin
        d_trial = {rem_reg[15:0], wk_reg[29]};
        d_ge    = (d_trial >= {1'b0, s_reg});
        d_diff  = d_trial - {1'b0, s_reg};
    end

    // One square root step: bring down two bits, try root*4+1.
    always_comb begin
        r_trial  = {rem_reg[16:0], wk_reg[31:30]};
        r_sub    = {1'b0, root_reg, 2'b01};
        r_ge     = (r_trial >= r_sub);
        r_diff   = r_trial - r_sub;
        axis_out = v_sel[7] ? -$signed(root_reg) : $signed(root_reg);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            vx_reg <= cond_axis(raw_x, dead_threshold, dead_offset);
            vy_reg <= cond_axis(raw_y, dead_threshold, dead_offset);
        end
        unique case (ctrl.op)
            jdrc_pkg::OP_SQ: begin
                t_reg <= sq_full[14:0];
            end
            jdrc_pkg::OP_SQ_ADD: begin
                s_reg <= {1'b0, t_reg} + {1'b0, sq_full[14:0]};
            end
            jdrc_pkg::OP_LIM_SQ: begin
                l2_reg <= l2_full;
            end
            jdrc_pkg::OP_DIV_INIT: begin
                // Dividend is square * limit squared * 65536; its top bits stay below s.
                rem_reg <= 19'(num_full[28:14]);
                wk_reg  <= {2'b00, num_full[13:0], 16'h0000};
            end
            jdrc_pkg::OP_DIV_STEP: begin
                rem_reg <= {2'b00, d_ge ? d_diff : d_trial};
                wk_reg  <= {2'b00, wk_reg[28:0], d_ge};
            end
            jdrc_pkg::OP_SQRT_QUO: begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            jdrc_pkg::OP_SQRT_SUM: begin
                rem_reg  <= '0;
                root_reg <= '0;
                wk_reg   <= {s_reg, 16'h0000};
            end
            jdrc_pkg::OP_SQRT_STEP: begin
                rem_reg  <= r_ge ? r_diff : r_trial;
                root_reg <= {root_reg[14:0], r_ge};
                wk_reg   <= {wk_reg[29:0], 2'b00};
            end
            jdrc_pkg::OP_STORE_AXIS: begin
                if (ctrl.axis == jdrc_pkg::AXIS_Y) begin
                    sy_reg <= axis_out;
                end else begin
                    sx_reg <= axis_out;
                end
            end
            jdrc_pkg::OP_STORE_RAW: begin
                sx_reg <= {vx_reg, 8'h00};
                sy_reg <= {vy_reg, 8'h00};
            end
            jdrc_pkg::OP_MAG_LIM: begin
                mag_reg <= {max_magnitude, 8'h00};
            end
            jdrc_pkg::OP_MAG_ROOT: begin
                mag_reg <= root_reg[14:0];
            end
            default: begin
            end
        endcase
    end

    assign stick_x         = sx_reg;
    assign stick_y         = sy_reg;
    assign stick_magnitude = mag_reg;

endmodule

@@ sv/joystick_deadzone_radial_clamp_unit.sv @@
// Analog stick dead zone, radial clamp and button edge unit, top level.
// When the vector is clamped the program runs two 30-step divides and two 16-step roots;
// the microcode program runs one poll at a time and the next is taken the cycle after
// the result enters the output register.
// Reset (aresetn low, synchronous) restores the register defaults, clears the previous
// button word and the output valid, and returns the sequencer to its idle step.
module joystick_deadzone_radial_clamp_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // raw_x[7:0], raw_y[15:8], buttons[31:16]
    input  logic [jdrc_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // stick_x[15:0], stick_y[31:16], stick_magnitude[46:32], held_buttons[62:47],
    // pressed_buttons[78:63], zero[79]
    output logic [jdrc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [jdrc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [jdrc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic [jdrc_pkg::CFG_DATA_W-1:0]  dead_threshold_reg, dead_offset_reg, max_magnitude_reg;
    logic [jdrc_pkg::BTN_W-1:0]       btn_reg, prev_btn_reg;
    logic [jdrc_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                             m_tvalid_reg;

    jdrc_pkg::ctrl_t   ctrl;
    jdrc_pkg::status_t stat;
    logic              idle, start, above;
    logic signed [jdrc_pkg::STICK_W-1:0] stick_x, stick_y;
    logic        [jdrc_pkg::MAG_W-1:0]   stick_magnitude;
    logic        [jdrc_pkg::BTN_W-1:0]   pressed;

    // Input side: one poll is taken while the sequencer sits in its idle step.
    assign s_tready = idle && aresetn;
    assign start    = s_tvalid && s_tready;

    always_comb begin
        stat.start    = start;
        stat.above    = above;
        stat.out_busy = m_tvalid_reg && !m_tready;
        pressed       = btn_reg & ~prev_btn_reg;
    end

    jdrc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl),
        .idle    (idle)
    );

    jdrc_datapath u_dp (
        .aclk            (aclk),
        .ctrl            (ctrl),
        .start           (start),
        .raw_x           (s_tdata[7:0]),
        .raw_y           (s_tdata[15:8]),
        .dead_threshold  (dead_threshold_reg),
        .dead_offset     (dead_offset_reg),
        .max_magnitude   (max_magnitude_reg),
        .above           (above),
        .stick_x         (stick_x),
        .stick_y         (stick_y),
        .stick_magnitude (stick_magnitude)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_threshold_reg <= jdrc_pkg::RST_DEAD_THRESHOLD;
            dead_offset_reg    <= jdrc_pkg::RST_DEAD_OFFSET;
            max_magnitude_reg  <= jdrc_pkg::RST_MAX_MAGNITUDE;
        end else if (cfg_wr_en) begin
            if (cfg_addr == jdrc_pkg::REG_DEAD_THRESHOLD) dead_threshold_reg <= cfg_wdata;
            if (cfg_addr == jdrc_pkg::REG_DEAD_OFFSET)    dead_offset_reg    <= cfg_wdata;
            if (cfg_addr == jdrc_pkg::REG_MAX_MAGNITUDE)  max_magnitude_reg  <= cfg_wdata;
        end
    end

    // Button word of the current poll.
    always_ff @(posedge aclk) begin
        if (start) begin
            btn_reg <= s_tdata[31:16];
        end
    end

    // Output register and previous button word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            prev_btn_reg <= '0;
        end else if (ctrl.op == jdrc_pkg::OP_OUT_WRITE) begin
            m_tvalid_reg <= 1'b1;
            prev_btn_reg <= btn_reg;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == jdrc_pkg::OP_OUT_WRITE) begin
            m_tdata_reg <= {1'b0, pressed, btn_reg, stick_magnitude, stick_y, stick_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/jdrc_checker.sv @@
// Port-level checker for the stick conditioning unit, bound to the top level.
`include "joystick_deadzone_radial_clamp_unit_assert.svh"

module jdrc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [jdrc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [jdrc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             cfg_wr_en,
    input logic [jdrc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input logic [jdrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // A stalled result transaction keeps its data.
    `JDRC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The unit works on one poll at a time: it is busy right after taking one.
    `JDRC_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a poll is in work")

    // A new result only appears at the end of a poll's program, never from idle.
    `JDRC_ASSERT_NOW(a_result_from_work, aclk, aresetn, $rose(m_tvalid), !$past(s_tready), "result appeared without a poll in work")

    // The padding bit of the result is always zero.
    `JDRC_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[79] == 1'b0, "result padding bit set")

endmodule

bind joystick_deadzone_radial_clamp_unit jdrc_checker u_jdrc_checker (.*);

@@ test/joystick_deadzone_radial_clamp_unit_tb.sv @@
// Self-checking testbench for the stick dead zone, radial clamp and button edge unit.
module joystick_deadzone_radial_clamp_unit_tb;
    import jdrc_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int ITEMS_PER_SEGMENT = 122;
    localparam int SEGMENTS          = 16;

    // One predicted output transaction.
    typedef struct {
        logic [STICK_W-1:0] stick_x;
        logic [STICK_W-1:0] stick_y;
        logic [MAG_W-1:0]   stick_magnitude;
        logic [BTN_W-1:0]   held_buttons;
        logic [BTN_W-1:0]   pressed_buttons;
        bit                 clamped;
    } stick_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Shadow copies of the registers and of the previous button word.
    logic [CFG_DATA_W-1:0]  shadow_threshold;
    logic [CFG_DATA_W-1:0]  shadow_offset;
    logic [CFG_DATA_W-1:0]  shadow_limit;
    logic [BTN_W-1:0]       prev_held;

    stick_report_t          pending_reports[$];
    int                     send_gap_pct;
    int                     recv_stall_pct;
    int                     idle_cycles = 0;
    int                     mismatches;
    int                     polls_sent;
    int                     reports_checked;
    int                     clamped_polls;
    int                     settings_used;

    joystick_deadzone_radial_clamp_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Integer square root, rounded down.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned place;
        root  = 0;
        place = 64'h4000_0000_0000_0000;
        while (place > n) place >>= 2;
        while (place != 0) begin
            if (n >= root + place) begin
                n    = n - (root + place);
                root = (root >> 1) + place;
            end else begin
                root = root >> 1;
            end
            place >>= 2;
        end
        return root;
    endfunction

    // Dead zone on one axis: readings at or past the threshold are shifted toward zero by the offset, others read zero.
    function automatic int dead_zone_axis(logic [AXIS_W-1:0] raw);
        int reading;
        int thr;
        int ofs;
        reading = $signed(raw);
        thr     = shadow_threshold;
        ofs     = shadow_offset;
        if (reading >= thr) return reading - ofs;
        if (reading <= -thr) return reading + ofs;
        return 0;
    endfunction

    // Clamped axis in Q7.8, exact and truncated toward zero.
    function automatic int clamped_axis(int v, longint unsigned sum_sq, longint unsigned lim);
        longint unsigned mag_v;
        longint unsigned quot;
        int root;
        mag_v = (v < 0) ? -v : v;
        quot  = (mag_v * mag_v * lim * lim * 64'd65536) / sum_sq;
        root  = int'(floor_sqrt(quot));
        return (v < 0) ? -root : root;
    endfunction

    // Expected output of one poll under the current shadow registers.
    function automatic stick_report_t condition_poll(logic [AXIS_W-1:0] rx,
                                                     logic [AXIS_W-1:0] ry,
                                                     logic [BTN_W-1:0]  btn);
        stick_report_t rep;
        int vx;
        int vy;
        int sx;
        int sy;
        longint unsigned lim;
        longint unsigned sum_sq;
        vx     = dead_zone_axis(rx);
        vy     = dead_zone_axis(ry);
        lim    = shadow_limit;
        sum_sq = vx * vx + vy * vy;
        if (sum_sq > lim * lim) begin
            sx = clamped_axis(vx, sum_sq, lim);
            sy = clamped_axis(vy, sum_sq, lim);
            rep.stick_magnitude = MAG_W'(lim * 256);
            rep.clamped = 1'b1;
        end else begin
            sx = vx * 256;
            sy = vy * 256;
            rep.stick_magnitude = MAG_W'(floor_sqrt(sum_sq << 16));
            rep.clamped = 1'b0;
        end
        rep.stick_x         = STICK_W'(sx);
        rep.stick_y         = STICK_W'(sy);
        rep.held_buttons    = btn;
        rep.pressed_buttons = btn & ~prev_held;
        return rep;
    endfunction

    // Offers one poll and records its expected report once accepted.
    task automatic send_poll(logic [AXIS_W-1:0] rx, logic [AXIS_W-1:0] ry,
                             logic [BTN_W-1:0] btn);
        stick_report_t rep;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {btn, ry, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rep = condition_poll(rx, ry, btn);
        pending_reports.push_back(rep);
        prev_held = btn;
        polls_sent++;
        if (rep.clamped) clamped_polls++;
    endtask

    // Stops offering polls and waits until every report has come back.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive cycles; the unit must be idle.
    task automatic set_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] ofs,
                              logic [CFG_DATA_W-1:0] lim);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DEAD_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_addr  <= REG_DEAD_OFFSET;
        cfg_wdata <= ofs;
        @(posedge aclk);
        cfg_addr  <= REG_MAX_MAGNITUDE;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_threshold = thr;
        shadow_offset    = ofs;
        shadow_limit     = lim;
        settings_used++;
    endtask

    task automatic report_field(string name, longint unsigned exp_val,
                                longint unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Result checker, receiver stalls and the idle counter for the watchdog.
    always @(posedge aclk) begin
        stick_report_t exp_rep;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("output transaction with no poll outstanding: 0x%0h", m_tdata);
                mismatches++;
            end else begin
                exp_rep = pending_reports.pop_front();
                report_field("stick_x", exp_rep.stick_x, m_tdata[15:0]);
                report_field("stick_y", exp_rep.stick_y, m_tdata[31:16]);
                report_field("stick_magnitude", exp_rep.stick_magnitude, m_tdata[46:32]);
                report_field("held_buttons", exp_rep.held_buttons, m_tdata[62:47]);
                report_field("pressed_buttons", exp_rep.pressed_buttons, m_tdata[78:63]);
                report_field("pad", 0, m_tdata[79]);
                reports_checked++;
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when nothing has moved for too long.
    initial begin
        @(posedge aclk);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Random axis reading, weighted toward the dead zone edges and the extremes.
    function automatic logic [AXIS_W-1:0] pick_axis();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(255);
            1: begin
                v = int'(shadow_threshold) + int'($urandom_range(4)) - 2;
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                case ($urandom_range(2))
                    0: v = 127;
                    1: v = -128;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(40)) - 20;
        endcase
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return AXIS_W'(v);
    endfunction

    // Random button word, often a small change from the previous poll.
    function automatic logic [BTN_W-1:0] pick_buttons();
        case ($urandom_range(3))
            0: return BTN_W'($urandom);
            1: return prev_held ^ (16'h0001 << $urandom_range(15));
            2: return prev_held | BTN_W'($urandom);
            default: return prev_held & BTN_W'($urandom);
        endcase
    endfunction

    // Register defaults after reset, dead zone boundaries and full-scale readings.
    task automatic test_reset_defaults();
        send_poll(8'sd0, 8'sd0, 16'h0000);
        send_poll(8'sd7, -8'sd7, 16'hFFFF);
        send_poll(8'sd8, -8'sd8, 16'h0000);
        send_poll(8'sd9, -8'sd9, 16'hA5A5);
        send_poll(8'sd127, 8'sd0, 16'h5A5A);
        send_poll(-8'sd128, 8'sd0, 16'hFFFF);
        send_poll(8'sd127, 8'sd127, 16'h8001);
        send_poll(-8'sd128, -8'sd128, 16'h0001);
        send_poll(8'sd0, -8'sd128, 16'h7FFE);
        drain_reports();
    endtask

    // Offset larger than the reading pushes the axis across zero.
    task automatic test_offset_crossing();
        set_config(7'd1, 7'd127, 7'd127);
        send_poll(8'sd1, -8'sd1, 16'h00FF);
        send_poll(8'sd0, 8'sd0, 16'hFF00);
        send_poll(-8'sd128, 8'sd127, 16'hFFFF);
        drain_reports();
    endtask

    // With a zero threshold every reading is deflected, zero included.
    task automatic test_zero_threshold();
        set_config(7'd0, 7'd5, 7'd127);
        send_poll(8'sd0, 8'sd0, 16'h1234);
        send_poll(8'sd1, -8'sd1, 16'hEDCB);
        drain_reports();
    endtask

    // A zero limit forces every nonzero vector to zero.
    task automatic test_zero_limit();
        set_config(7'd8, 7'd6, 7'd0);
        send_poll(8'sd0, 8'sd0, 16'h0000);
        send_poll(8'sd100, -8'sd3, 16'hFFFF);
        send_poll(-8'sd3, 8'sd100, 16'h0000);
        send_poll(8'sd3, 8'sd3, 16'hFFFF);
        drain_reports();
    endtask

    // Largest threshold and offset, and the vector exactly at the largest limit.
    task automatic test_limit_edges();
        set_config(7'd127, 7'd127, 7'd1);
        send_poll(8'sd127, -8'sd128, 16'h8000);
        send_poll(8'sd126, -8'sd127, 16'h0001);
        drain_reports();
        set_config(7'd8, 7'd0, 7'd127);
        send_poll(8'sd127, 8'sd127, 16'hC3C3);
        send_poll(8'sd127, 8'sd0, 16'h3C3C);
        drain_reports();
    endtask

    // Random polls over every flow-control mode and a spread of register settings.
    task automatic test_random_traffic();
        int gap_modes[4]   = '{0, 58, 0, 26};
        int stall_modes[4] = '{0, 0, 58, 26};
        logic [CFG_DATA_W-1:0] corner_thr[4] = '{7'd8, 7'd0, 7'd127, 7'd1};
        logic [CFG_DATA_W-1:0] corner_ofs[4] = '{7'd6, 7'd127, 7'd0, 7'd127};
        logic [CFG_DATA_W-1:0] corner_lim[4] = '{7'd64, 7'd0, 7'd127, 7'd1};
        int mode;
        int thr;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mode = seg / 4;
            drain_reports();
            case (seg % 4)
                0: set_config(corner_thr[mode], corner_ofs[mode], corner_lim[mode]);
                2: begin
                    thr = $urandom_range(24, 1);
                    set_config(CFG_DATA_W'(thr), CFG_DATA_W'($urandom_range(thr)),
                               CFG_DATA_W'($urandom_range(127, 16)));
                end
                default: set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                    CFG_DATA_W'($urandom));
            endcase
            send_gap_pct   = gap_modes[mode];
            recv_stall_pct = stall_modes[mode];
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
                send_poll(pick_axis(), pick_axis(), pick_buttons());
            end
        end
        drain_reports();
    endtask

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_wr_en        = 1'b0;
        cfg_addr         = REG_DEAD_THRESHOLD;
        cfg_wdata        = '0;
        shadow_threshold = RST_DEAD_THRESHOLD;
        shadow_offset    = RST_DEAD_OFFSET;
        shadow_limit     = RST_MAX_MAGNITUDE;
        prev_held        = '0;
        send_gap_pct     = 0;
        recv_stall_pct   = 0;
        mismatches       = 0;
        polls_sent       = 0;
        reports_checked  = 0;
        clamped_polls    = 0;
        settings_used    = 1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_offset_crossing();
        test_zero_threshold();
        test_zero_limit();
        test_limit_edges();
        test_random_traffic();

        // Let any stray output show up before closing.
        repeat (120) @(posedge aclk);

        $display("Sent %0d polls, checked %0d reports, %0d of them clamped.",
                 polls_sent, reports_checked, clamped_polls);
        $display("Used %0d register settings across four flow-control modes.",
                 settings_used);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/jdrc_pkg.sv
sv/jdrc_seq.sv
sv/jdrc_datapath.sv
sv/joystick_deadzone_radial_clamp_unit.sv
sv/jdrc_checker.sv
test/joystick_deadzone_radial_clamp_unit_tb.sv
